/* sv/pump_dry_run_detector_macros.svh */
// Assertion helpers used by pump_dry_run_detector.sv to check its own logic.
`ifndef PUMP_DRY_RUN_DETECTOR_MACROS_SVH
`define PUMP_DRY_RUN_DETECTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdrd: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PDRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdrd: next-cycle check failed");

`endif

/* sv/pdrd_pkg.sv */
package pdrd_pkg;

  localparam int CHANNELS   = 2;
  localparam int CH_W       = 1;
  localparam int ADC_W      = 12;
  localparam int MV_W       = 12;
  localparam int MS_W       = 16;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = 24;  // adc code times full-scale millivolts
  localparam int LHS_W      = 22;  // |mv - zero| times 1000
  localparam int RHS_W      = 28;  // threshold mA times mV per A
  localparam int DIV_SH     = 12;

  localparam logic [MV_W-1:0]  ADC_FULL_MV = 12'd3300;
  localparam logic [ADC_W-1:0] ADC_DIVISOR = 12'd4095;
  localparam logic [9:0]       MA_PER_A    = 10'd1000;

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MV_PER_AMP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRY_THRESH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM     = 3'd4;

  localparam logic [MV_W-1:0] RST_ZERO_OFFSET = 12'd1650;
  localparam logic [MV_W-1:0] RST_MV_PER_AMP  = 12'd185;
  localparam logic [MS_W-1:0] RST_DRY_THRESH  = 16'd100;
  localparam logic [MS_W-1:0] RST_STARTUP     = 16'd2000;
  localparam logic [MS_W-1:0] RST_CONFIRM     = 16'd3000;

  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic              on;
    logic [TIME_W-1:0] now;
  } pdrd_tag_t;

  typedef struct packed {
    pdrd_tag_t         tag;
    logic [LHS_W-1:0]  lhs;
  } pdrd_item_t;

endpackage

/* sv/pdrd_in_if.sv */
interface pdrd_in_if;
  import pdrd_pkg::*;

  logic                valid;
  logic                ready;
  logic [CH_W-1:0]     channel;
  logic                pump_on;
  logic [ADC_W-1:0]    adc_raw;
  logic [TIME_W-1:0]   now_ms;

  modport source (output valid, output channel, output pump_on, output adc_raw,
                  output now_ms, input ready);
  modport sink (input valid, input channel, input pump_on, input adc_raw,
                input now_ms, output ready);
endinterface

/* sv/pdrd_out_if.sv */
interface pdrd_out_if;
  import pdrd_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_channel;
  logic            dry_detected;
  logic            below_active;
  logic            in_blanking;

  modport source (output valid, output out_channel, output dry_detected,
                  output below_active, output in_blanking, input ready);
  modport sink (input valid, input out_channel, input dry_detected,
                input below_active, input in_blanking, output ready);
endinterface

/* sv/pdrd_front.sv */
// Current-sense pipeline: input register, millivolt product, millivolt
// conversion and offset distance, then the distance times 1000 (mA per A).
module pdrd_front (
  input  logic                            clk,
  input  logic                            rst_n,
  pdrd_in_if.sink                         in_smp,
  input  logic [pdrd_pkg::MV_W-1:0]       zero_offset_mv,
  output pdrd_pkg::pdrd_item_t            item,
  output logic                            item_valid,
  input  logic                            item_ready
);
  import pdrd_pkg::*;

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic rdy1, rdy2, rdy3, rdy4;

  pdrd_tag_t          s1_tag_r, s2_tag_r, s3_tag_r, s4_tag_r;
  logic [ADC_W-1:0]   s1_raw_r;
  logic [PROD_W-1:0]  s2_prod_r;
  logic [MV_W-1:0]    s3_diff_r;
  logic [LHS_W-1:0]   s4_lhs_r;

  logic [PROD_W:0]    est_sum;
  logic [MV_W-1:0]    q0;
  logic [PROD_W-1:0]  q0_mul;
  logic [PROD_W-1:0]  rem;
  logic [MV_W-1:0]    mv;
  logic [MV_W-1:0]    diff;

  // A stage takes new data when it is empty or its successor moves on.
  assign rdy4 = !s4_v_r || item_ready;
  assign rdy3 = !s3_v_r || rdy4;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;
  assign in_smp.ready = rdy1;

  // floor(x / 4095): the estimate (x + x/4096) / 4096 is low by at most one,
  // so a single remainder check finishes the quotient.
  always_comb begin
    est_sum = {1'b0, s2_prod_r} + (PROD_W + 1)'(s2_prod_r >> DIV_SH);
    q0      = est_sum[DIV_SH +: MV_W];
    q0_mul  = {q0, {DIV_SH{1'b0}}} - PROD_W'(q0);
    rem     = s2_prod_r - q0_mul;
    mv      = (rem >= PROD_W'(ADC_DIVISOR)) ? q0 + MV_W'(1) : q0;
    diff    = (mv >= zero_offset_mv) ? mv - zero_offset_mv : zero_offset_mv - mv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= in_smp.valid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
      if (rdy4) s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_tag_r <= '{ch: in_smp.channel, on: in_smp.pump_on, now: in_smp.now_ms};
      s1_raw_r <= in_smp.adc_raw;
    end
    if (rdy2) begin
      s2_tag_r  <= s1_tag_r;
      s2_prod_r <= PROD_W'(s1_raw_r) * PROD_W'(ADC_FULL_MV);
    end
    if (rdy3) begin
      s3_tag_r  <= s2_tag_r;
      s3_diff_r <= diff;
    end
    if (rdy4) begin
      s4_tag_r <= s3_tag_r;
      s4_lhs_r <= LHS_W'(s3_diff_r) * LHS_W'(MA_PER_A);
    end
  end

  assign item       = '{tag: s4_tag_r, lhs: s4_lhs_r};
  assign item_valid = s4_v_r;

endmodule

/* sv/pump_dry_run_detector.sv */
// Channel    Direction  Handshake            Payload
// in_smp     sink       valid/ready          channel, pump_on, adc_raw, now_ms
// out_res    source     valid/ready          out_channel, dry_detected,
//                                            below_active, in_blanking
// cfg        write      cfg_we               cfg_idx, cfg_wdata
//
// One transaction per cycle sustained while out_res is ready. The first of
// the four current-sense stages takes the transaction at input acceptance,
// and three more stages lead to the result register where the per-channel
// state is updated.
// rst_n is synchronous and active low; it restores the register defaults and
// clears every channel. A stalled output fills the pipeline bubbles first and
// then holds ready low on the input.
`include "pump_dry_run_detector_macros.svh"

module pump_dry_run_detector (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pdrd_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [pdrd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  pdrd_in_if.sink                            in_smp,
  pdrd_out_if.source                         out_res
);
  import pdrd_pkg::*;

  logic [MV_W-1:0]  zero_offset_r, mv_per_amp_r;
  logic [MS_W-1:0]  dry_thresh_r, startup_r, confirm_r;
  logic [RHS_W-1:0] rhs_r;

  logic              running_r   [CHANNELS];
  logic              ltv_r       [CHANNELS];
  logic              dry_r       [CHANNELS];
  logic [TIME_W-1:0] on_since_r  [CHANNELS];
  logic [TIME_W-1:0] low_since_r [CHANNELS];

  logic              out_v_r, out_dry_r, out_below_r, out_blank_r;
  logic [CH_W-1:0]   out_ch_r;

  pdrd_item_t        item;
  logic              item_valid, item_ready, s4_fire;

  logic [CH_W-1:0]   c;
  logic              turn_on, running_nxt, ltv_nxt, dry_nxt, low_start, blank, is_low;
  logic [TIME_W-1:0] on_since_nxt, on_elapsed, low_elapsed;

  pdrd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_smp         (in_smp),
    .zero_offset_mv (zero_offset_r),
    .item           (item),
    .item_valid     (item_valid),
    .item_ready     (item_ready)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_offset_r <= RST_ZERO_OFFSET;
      mv_per_amp_r  <= RST_MV_PER_AMP;
      dry_thresh_r  <= RST_DRY_THRESH;
      startup_r     <= RST_STARTUP;
      confirm_r     <= RST_CONFIRM;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ZERO_OFFSET: zero_offset_r <= cfg_wdata[MV_W-1:0];
        REG_MV_PER_AMP:  mv_per_amp_r  <= cfg_wdata[MV_W-1:0];
        REG_DRY_THRESH:  dry_thresh_r  <= cfg_wdata;
        REG_STARTUP:     startup_r     <= cfg_wdata;
        REG_CONFIRM:     confirm_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The threshold product depends only on configuration.
  always_ff @(posedge clk) begin
    rhs_r <= RHS_W'(dry_thresh_r) * RHS_W'(mv_per_amp_r);
  end

  assign item_ready = !out_v_r || out_res.ready;
  assign s4_fire    = item_valid && item_ready;

  always_comb begin
    c            = item.tag.ch;
    is_low       = {{(RHS_W - LHS_W){1'b0}}, item.lhs} < rhs_r;
    turn_on      = item.tag.on && !running_r[c];
    running_nxt  = item.tag.on;
    on_since_nxt = turn_on ? item.tag.now : on_since_r[c];
    ltv_nxt      = ltv_r[c];
    dry_nxt      = dry_r[c];
    // Any change of the pump command restarts the channel.
    if (item.tag.on != running_r[c]) begin
      ltv_nxt = 1'b0;
      dry_nxt = 1'b0;
    end
    on_elapsed  = item.tag.now - on_since_nxt;
    low_elapsed = item.tag.now - low_since_r[c];
    blank       = 1'b0;
    low_start   = 1'b0;
    if (running_nxt) begin
      priority if (on_elapsed < TIME_W'(startup_r)) begin
        blank = 1'b1;
      end else if (is_low) begin
        if (!ltv_nxt) begin
          ltv_nxt   = 1'b1;
          low_start = 1'b1;
        end else if (low_elapsed > TIME_W'(confirm_r)) begin
          dry_nxt = 1'b1;
        end
      end else begin
        ltv_nxt = 1'b0;
        dry_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        running_r[i] <= 1'b0;
        ltv_r[i]     <= 1'b0;
        dry_r[i]     <= 1'b0;
      end
    end else if (s4_fire) begin
      out_v_r      <= 1'b1;
      running_r[c] <= running_nxt;
      ltv_r[c]     <= ltv_nxt;
      dry_r[c]     <= dry_nxt;
    end else if (out_res.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_fire) begin
      on_since_r[c] <= on_since_nxt;
      if (low_start) low_since_r[c] <= item.tag.now;
      out_ch_r    <= c;
      out_dry_r   <= dry_nxt;
      out_below_r <= ltv_nxt;
      out_blank_r <= blank;
    end
  end

  assign out_res.valid        = out_v_r;
  assign out_res.out_channel  = out_ch_r;
  assign out_res.dry_detected = out_dry_r;
  assign out_res.below_active = out_below_r;
  assign out_res.in_blanking  = out_blank_r;

  // A confirmed dry condition always sits on a running confirm timer.
  `PDRD_ASSERT_NOW(a_dry_needs_timer, clk, rst_n, out_v_r && out_dry_r, out_below_r)
  // A held result must not be replaced by a new transaction.
  `PDRD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_v_r && !out_res.ready, out_v_r && $stable(out_ch_r))

  for (genvar g = 0; g < CHANNELS; g++) begin : g_chk
    // An idle channel carries no timer and no dry flag.
    `PDRD_ASSERT_NOW(a_idle_clear, clk, rst_n, !running_r[g], !ltv_r[g] && !dry_r[g])
  end

endmodule
